FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/stfs_pkg.sv
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared types and constants of the shared-track frame selector.
// ----------------------------------------------------------------------------
`default_nettype none
package stfs_pkg;
    localparam int MaxFrames = 32;
    localparam int MaxPoints = 1024;
    localparam int FrmW  = $clog2(MaxFrames);
    localparam int PntW  = $clog2(MaxPoints);
    localparam int NfW   = FrmW + 1;
    localparam int NpW   = PntW + 1;
    localparam int WgtW  = FrmW + 1;
    localparam int AccW  = PntW + WgtW + 1;

    typedef enum logic [2:0] {
        OP_TRACK   = 3'd0,
        OP_PENDING = 3'd1,
        OP_REG     = 3'd2,
        OP_PAIR    = 3'd3,
        OP_NEXT    = 3'd4
    } t_opcode;

    localparam logic CFG_FRAMES = 1'b0;
    localparam logic CFG_POINTS = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic            wipe;      // clearing pass write of zero at {fi, k}
        logic            load;      // take a load request
        logic            clr_best;  // start of search
        logic            clr_acc;   // start of one inner sweep
        logic            wgt_step;  // weight phase step
        logic            pair_step; // pair accumulate step
        logic            next_step; // next-frame accumulate step
        logic            cmp_pair;  // fold pair sum into best
        logic            cmp_next;  // fold count into best
        logic [FrmW-1:0] fi;
        logic [FrmW-1:0] fj;
        logic [PntW-1:0] k;
    } t_ctl;
endpackage
`default_nettype wire

FILE: hw/rtl/stfs_datapath.sv
// ----------------------------------------------------------------------------
// stfs_datapath
// Bit matrix, masks, weight memory, accumulator and best-so-far registers.
// ----------------------------------------------------------------------------
`default_nettype none
module stfs_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire stfs_pkg::t_ctl              i_ctl,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [stfs_pkg::FrmW-1:0]   i_frame_index,
    input  wire logic [stfs_pkg::PntW-1:0]   i_point_index,
    input  wire logic                        i_bit_value,
    output logic                             o_found,
    output logic [stfs_pkg::FrmW-1:0]        o_frame_a,
    output logic [stfs_pkg::FrmW-1:0]        o_frame_b,
    output logic [15:0]                      o_score
);
    localparam int Fw = stfs_pkg::FrmW;
    localparam int Pw = stfs_pkg::PntW;
    localparam int Depth = stfs_pkg::MaxFrames * stfs_pkg::MaxPoints;

    // matrix is a memory: one write and one pair of reads per cycle
    logic                          mat [Depth];
    logic [stfs_pkg::WgtW-1:0]     wgt [stfs_pkg::MaxPoints];
    logic                          regd [stfs_pkg::MaxPoints];
    logic [stfs_pkg::MaxFrames-1:0] r_pending;
    logic                          r_bit_i, r_bit_j;
    logic [stfs_pkg::WgtW-1:0]     r_wgt_rd;
    logic                          r_regd_rd;
    logic [stfs_pkg::WgtW-1:0]     r_wcnt;
    logic [stfs_pkg::AccW-1:0]     r_acc;
    logic [stfs_pkg::AccW-1:0]     n_acc;
    logic [stfs_pkg::AccW-1:0]     acc_base;
    logic [stfs_pkg::AccW-1:0]     r_best;
    logic                          r_found;
    logic [Fw-1:0]                 r_fa, r_fb;
    stfs_pkg::t_ctl                r_ctl_d;   // command aligned with read data
    logic [Pw-1:0]                 r_k_d;

    wire logic [Fw+Pw-1:0] rd_i    = {i_ctl.fi, i_ctl.k};
    wire logic [Fw+Pw-1:0] rd_j    = {i_ctl.fj, i_ctl.k};
    wire logic [Fw+Pw-1:0] wr_addr = i_ctl.wipe ? rd_i : {i_frame_index, i_point_index};
    wire logic [Pw-1:0]    rg_addr = i_ctl.wipe ? i_ctl.k : i_point_index;
    wire logic             wr_bit  = i_bit_value && !i_ctl.wipe;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wipe || (i_ctl.load && i_opcode == stfs_pkg::OP_TRACK)) begin
            mat[wr_addr] <= wr_bit;
        end
        if (i_ctl.wipe || (i_ctl.load && i_opcode == stfs_pkg::OP_REG)) begin
            regd[rg_addr] <= wr_bit;
        end
        r_bit_i   <= mat[rd_i];
        r_bit_j   <= mat[rd_j];
        r_wgt_rd  <= wgt[i_ctl.k];
        r_regd_rd <= regd[i_ctl.k];
        r_k_d     <= i_ctl.k;
        // weight written as its last frame bit is added to the running count
        if (r_ctl_d.wgt_step && r_ctl_d.cmp_pair) begin
            wgt[r_k_d] <= r_wcnt + {{(stfs_pkg::WgtW-1){1'b0}}, r_bit_i};
        end
    end

    always_comb begin
        acc_base = r_ctl_d.clr_acc ? '0 : r_acc;
        n_acc = acc_base;
        if (r_ctl_d.pair_step && r_bit_i && r_bit_j) begin
            n_acc = acc_base + {{(stfs_pkg::AccW-stfs_pkg::WgtW){1'b0}}, r_wgt_rd};
        end else if (r_ctl_d.next_step && r_bit_i && r_regd_rd
                     && r_pending[r_ctl_d.fi]) begin
            n_acc = acc_base + {{(stfs_pkg::AccW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_ctl_d   <= '0;
            r_found   <= 1'b0;
        end else begin
            r_ctl_d <= i_ctl;
            if (i_ctl.load && i_opcode == stfs_pkg::OP_PENDING) begin
                r_pending[i_frame_index] <= i_bit_value;
            end
            if (i_ctl.clr_best) begin
                r_found <= 1'b0;
            end else if (r_ctl_d.cmp_pair && !r_ctl_d.wgt_step
                         && n_acc >= r_best) begin
                r_found <= 1'b1;
            end else if (r_ctl_d.cmp_next && n_acc > r_best) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl_d.wgt_step) begin
            if (r_ctl_d.fi == '0) begin
                r_wcnt <= {{(stfs_pkg::WgtW-1){1'b0}}, r_bit_i};
            end else begin
                r_wcnt <= r_wcnt + {{(stfs_pkg::WgtW-1){1'b0}}, r_bit_i};
            end
        end
        r_acc <= n_acc;
        if (r_ctl_d.clr_best) begin
            r_best <= '0;
            r_fa   <= '0;
            r_fb   <= '0;
        end else if (r_ctl_d.cmp_pair && !r_ctl_d.wgt_step && n_acc >= r_best) begin
            r_best <= n_acc;
            r_fa   <= r_ctl_d.fi;
            r_fb   <= r_ctl_d.fj;
        end else if (r_ctl_d.cmp_next && n_acc > r_best) begin
            r_best <= n_acc;
            r_fa   <= r_ctl_d.fi;
            r_fb   <= '0;
        end
    end

    assign o_found   = r_found;
    assign o_frame_a = r_found ? r_fa : '0;
    assign o_frame_b = r_found ? r_fb : '0;
    assign o_score   = !r_found ? 16'd0 :
                       (|r_best[stfs_pkg::AccW-1:16]) ? 16'hFFFF : r_best[15:0];
endmodule
`default_nettype wire

FILE: hw/rtl/stfs_ctrl.sv
// ----------------------------------------------------------------------------
// stfs_ctrl
// Sequencer: clears the matrix after reset, takes loads, walks the searches.
// ----------------------------------------------------------------------------
`default_nettype none
module stfs_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_out_busy,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [stfs_pkg::NfW-1:0]    i_nf,
    input  wire logic [stfs_pkg::NpW-1:0]    i_np,
    output stfs_pkg::t_ctl                   o_ctl,
    output logic                             o_done,
    output logic                             o_kind
);
    localparam int Fw = stfs_pkg::FrmW;
    localparam int Pw = stfs_pkg::PntW;
    localparam logic [Fw:0]    FOne   = (Fw+1)'(1);
    localparam logic [Fw:0]    FTwo   = (Fw+1)'(2);
    localparam logic [Pw:0]    KOne   = (Pw+1)'(1);
    localparam logic [Fw+Pw:0] ClrOne = (Fw+Pw+1)'(1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WGT, S_GAP, S_PAIR, S_NEXT, S_DRAIN, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [Fw:0]   r_i, n_i, r_j, n_j;
    logic [Pw:0]   r_k, n_k;
    logic [Fw+Pw:0] r_clr, n_clr;
    logic          r_kind, n_kind;
    logic [1:0]    r_drain, n_drain;
    logic          take;
    wire logic     k_last = (r_k + KOne >= i_np) || (r_k == {1'b0, {Pw{1'b1}}});

    assign o_in_stall = (r_state != S_IDLE);
    assign take       = i_in_valid && r_state == S_IDLE && !i_out_busy;

    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j; n_k = r_k;
        n_clr = r_clr; n_kind = r_kind; n_drain = r_drain;
        o_ctl = '0;
        o_ctl.fi = r_i[Fw-1:0];
        o_ctl.fj = r_j[Fw-1:0];
        o_ctl.k  = r_k[Pw-1:0];
        unique case (r_state)
            S_CLEAR: begin
                // write zero over every matrix and registered-point entry
                o_ctl.wipe = !r_clr[Fw+Pw];
                o_ctl.fi   = r_clr[Fw+Pw-1:Pw];
                o_ctl.k    = r_clr[Pw-1:0];
                n_clr = r_clr + ClrOne;
                if (r_clr[Fw+Pw]) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ctl.load = take;
                o_ctl.clr_best = 1'b1;
                o_ctl.clr_acc = 1'b1;
                n_i = '0; n_j = '0; n_k = '0;
                if (take && i_opcode == stfs_pkg::OP_PAIR) begin
                    n_kind = 1'b0;
                    if (i_nf < FTwo) begin
                        n_state = S_DRAIN; n_drain = 2'd3;
                    end else if (i_np == '0) begin
                        // zero score pairs still count: walk the pairs with no points
                        n_i = FOne;
                        n_state = S_PAIR;
                    end else begin
                        n_state = S_WGT;
                    end
                end else if (take && i_opcode == stfs_pkg::OP_NEXT) begin
                    n_kind = 1'b1;
                    n_state = (i_nf == '0 || i_np == '0) ? S_DRAIN : S_NEXT;
                    n_drain = 2'd3;
                end
            end
            S_WGT: begin
                o_ctl.wgt_step = 1'b1;
                o_ctl.cmp_pair = (r_i + FOne == i_nf);
                if (r_i + FOne == i_nf) begin
                    n_i = '0;
                    if (k_last) begin
                        n_k = '0; n_i = FOne; n_j = '0;
                        n_state = S_GAP;
                    end else n_k = r_k + KOne;
                end else n_i = r_i + FOne;
            end
            // let the last weight land before it is read
            S_GAP: n_state = S_PAIR;
            S_PAIR: begin
                o_ctl.pair_step = (i_np != '0);
                o_ctl.clr_acc = (r_k == '0);
                o_ctl.cmp_pair = k_last;
                if (k_last) begin
                    n_k = '0;
                    if (r_j + FOne == r_i) begin
                        n_j = '0;
                        if (r_i + FOne == i_nf) begin
                            n_state = S_DRAIN; n_drain = 2'd3;
                        end else n_i = r_i + FOne;
                    end else n_j = r_j + FOne;
                end else n_k = r_k + KOne;
            end
            S_NEXT: begin
                o_ctl.next_step = 1'b1;
                o_ctl.clr_acc = (r_k == '0);
                o_ctl.cmp_next = k_last;
                if (k_last) begin
                    n_k = '0;
                    if (r_i + FOne == i_nf) begin
                        n_state = S_DRAIN; n_drain = 2'd3;
                    end else n_i = r_i + FOne;
                end else n_k = r_k + KOne;
            end
            S_DRAIN: begin
                n_drain = r_drain - 2'd1;
                if (r_drain == 2'd1) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_i <= '0; r_j <= '0; r_k <= '0;
            r_clr <= '0; r_kind <= 1'b0; r_drain <= '0;
        end else begin
            r_state <= n_state; r_i <= n_i; r_j <= n_j; r_k <= n_k;
            r_clr <= n_clr; r_kind <= n_kind; r_drain <= n_drain;
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_kind = r_kind;
endmodule
`default_nettype wire

FILE: hw/rtl/shared_track_frame_selector.sv
// ----------------------------------------------------------------------------
// shared_track_frame_selector
// Frame pair and next-frame selection over a frame-by-point track bit matrix.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | i_in_valid/o_in_stall  | opcode, frame_index, point_index, bit_value
//  out     | o_out_valid/i_out_stall| search_kind, found, frame_a, frame_b, score
//  cfg     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  A pair search walks a weight pass over every frame and point, the gap state
//  and a pair pass over each frame pair at every point (the pairs alone, with no
//  weight pass, when np is 0); a next search walks every point of every frame;
//  a search with nothing to walk goes straight to the drain. Drain and hand-off
//  states follow before the result is valid. Reset starts a clearing pass first.
//  A result waits in the output register; no new request is taken meanwhile.
`default_nettype none
`include "assert_macros.svh"
module shared_track_frame_selector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [4:0]  i_frame_index,
    input  wire logic [9:0]  i_point_index,
    input  wire logic        i_bit_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_search_kind,
    output logic             o_found,
    output logic [4:0]       o_frame_a,
    output logic [4:0]       o_frame_b,
    output logic [15:0]      o_score,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    logic [5:0]  r_frames;
    logic [10:0] r_points;
    logic [stfs_pkg::NfW-1:0] nf;
    logic [stfs_pkg::NpW-1:0] np;
    stfs_pkg::t_ctl ctl;
    logic done, kind, c_stall, d_found;
    logic [4:0] d_fa, d_fb;
    logic [15:0] d_score;

    assign o_cfg_ready = 1'b1;
    assign nf = (r_frames > 6'd32) ? 6'd32 : r_frames;
    assign np = (r_points > 11'd1024) ? 11'd1024 : r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= 6'd32; r_points <= 11'd1024;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == stfs_pkg::CFG_FRAMES) r_frames <= i_cfg_data[5:0];
            else r_points <= i_cfg_data;
        end
    end

    stfs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall(c_stall), .i_out_busy(o_out_valid),
        .i_opcode, .i_nf(nf), .i_np(np), .o_ctl(ctl), .o_done(done), .o_kind(kind)
    );

    stfs_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_opcode, .i_frame_index, .i_point_index,
        .i_bit_value, .o_found(d_found), .o_frame_a(d_fa), .o_frame_b(d_fb),
        .o_score(d_score)
    );

    // hold new requests while a result waits
    assign o_in_stall = c_stall || o_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (done) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (done) begin
            o_search_kind <= kind; o_found <= d_found; o_frame_a <= d_fa;
            o_frame_b <= d_fb; o_score <= d_score;
        end
    end

    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, done, o_out_valid)
    `ASSERT_CLK(a_no_take_busy, i_clk, i_rst_n, !(o_out_valid && !o_in_stall))
endmodule
`default_nettype wire
